/* rtl/seven_segment_display_refresher_core_macros.svh */
// Assertion macros shared by the refresher RTL.
`ifndef SEVEN_SEGMENT_DISPLAY_REFRESHER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_REFRESHER_CORE_MACROS_SVH

// Same-cycle implication.
`define SSDR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ssdr_pkg.sv */
package ssdr_pkg;

   localparam int PORTS_DEF      = 20;
   localparam int PORTS_PER_CHIP = 5;
   localparam int SEG_BYTES      = PORTS_PER_CHIP * 3;
   localparam int PAIRS          = (SEG_BYTES + 1) / 2;
   localparam int IDX_W          = 5;
   localparam int CHAN_W         = 5;
   localparam int CNT_W          = 3;

   localparam logic [7:0] BYTE_SETUP   = 8'h40;
   localparam logic [7:0] BYTE_ADDR    = 8'hC0;
   localparam logic [7:0] BYTE_DISP_ON = 8'h8F;

   localparam int MOD_DIV     = 1000;
   localparam int RECIP       = 16777;
   localparam int RECIP_SHIFT = 24;
   localparam int HUNDRED     = 100;
   localparam int TEN         = 10;

   localparam logic [CHAN_W-1:0] CHAN_TWO_CHIPS  = 5'd10;
   localparam logic [CHAN_W-1:0] CHAN_FOUR_CHIPS = 5'd20;
   localparam logic [CHAN_W-1:0] CHAN_RESET      = 5'd20;

   localparam logic CSR_CHANNEL_COUNT = 1'b0;

   typedef struct packed {
      logic [4:0]  port;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] chip;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       pair;
      logic       end_of_transaction;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       vld;
      logic [7:0] hundreds;
      logic [7:0] tens;
      logic [7:0] ones;
   } trio_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

/* rtl/ssdr_digits.sv */
module ssdr_digits (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic [15:0]        in_value,
   output ssdr_pkg::trio_type trio
);
   import ssdr_pkg::*;

   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [30:0] prod_ff;
   logic [15:0] val_ff;
   logic [9:0]  r_ff;
   logic [3:0]  h_ff;
   logic [6:0]  rem_ff;
   logic [7:0]  seg_h_ff, seg_t_ff, seg_o_ff;

   logic [6:0]  q;
   logic [16:0] diff;
   logic [9:0]  r_in;
   logic [3:0]  h_in;
   logic [9:0]  base_h;
   logic [3:0]  t_in;
   logic [6:0]  base_t;
   logic [3:0]  o_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // value mod 1000 via reciprocal estimate, then one correction
   always_comb begin
      q    = prod_ff[RECIP_SHIFT+6:RECIP_SHIFT];
      diff = {1'b0, val_ff} - 17'(q) * 17'(MOD_DIV);
      r_in = (diff >= 17'(MOD_DIV)) ? 10'(diff - 17'(MOD_DIV)) : 10'(diff);
   end

   always_comb begin
      h_in   = 4'd0;
      base_h = 10'd0;
      for (int d = 1; d < 10; d++) begin
         if (r_ff >= 10'(d * HUNDRED)) begin
            h_in   = 4'(d);
            base_h = 10'(d * HUNDRED);
         end
      end
   end

   always_comb begin
      t_in   = 4'd0;
      base_t = 7'd0;
      for (int d = 1; d < 10; d++) begin
         if (rem_ff >= 7'(d * TEN)) begin
            t_in   = 4'(d);
            base_t = 7'(d * TEN);
         end
      end
      o_in = 4'(rem_ff - base_t);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= 31'(in_value) * 31'(RECIP);
      val_ff   <= in_value;
      r_ff     <= r_in;
      h_ff     <= h_in;
      rem_ff   <= 7'(r_ff - base_h);
      seg_h_ff <= seg_code(h_ff);
      seg_t_ff <= seg_code(t_in);
      seg_o_ff <= seg_code(o_in);
   end

   assign trio.vld      = s4_vld_ff;
   assign trio.hundreds = seg_h_ff;
   assign trio.tens     = seg_t_ff;
   assign trio.ones     = seg_o_ff;

endmodule

/* rtl/seven_segment_display_refresher_core.sv */
// Update: the table entry is compared and written in the cycle after acceptance.
// Refresh, per chip: 5 table reads, a wait while the digit pipeline drains,
// 8 pair beats, 1 display-on beat; over four chips for a channel count of 20, two for 10.
// The first result is registered in ST_CONV, which follows ST_LOOKUP; one item at a time.
// Reset is synchronous: table valid bits clear at once, channel count is 20.
`include "seven_segment_display_refresher_core_macros.svh"

module seven_segment_display_refresher_core #(
   parameter int PORTS = ssdr_pkg::PORTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ssdr_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output ssdr_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ssdr_pkg::*;

   localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CONV,
      ST_WAIT,
      ST_DATA,
      ST_DISPON
   } state_type;

   state_type         state_ff;
   logic [1:0]        chip_ff, last_chip_ff;
   logic [CNT_W-1:0]  slot_ff, push_ff, pair_ff;
   logic [AW-1:0]     upd_addr_ff;
   logic [15:0]       upd_value_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [15:0]       mem_ff [PORTS];
   logic [PORTS-1:0]  vld_ff;
   logic [15:0]       rd_data_ff;
   logic              rd_zero_ff;
   logic              rd_vld_ff;
   logic [7:0]        seg_ff [SEG_BYTES];

   logic [IDX_W-1:0]  rd_idx;
   logic              rd_ok;
   logic [AW-1:0]     rd_addr;
   logic [15:0]       cur_value;
   logic              port_ok;
   logic              mem_we;
   logic              csr_write;
   trio_type          trio;

   assign port_ok = (req_data.port != 5'd0) && (req_data.port <= 5'(PORTS));
   assign rd_idx  = (state_ff == ST_IDLE) ? 5'(req_data.port - 5'd1)
                  : 5'(5'(chip_ff) * 5'(PORTS_PER_CHIP) + 5'(slot_ff));
   assign rd_ok   = rd_idx < 5'(PORTS);
   assign rd_addr = rd_idx[AW-1:0];
   assign cur_value = rd_zero_ff ? 16'd0 : rd_data_ff;
   assign mem_we  = (state_ff == ST_LOOKUP) && (cur_value != upd_value_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[upd_addr_ff] <= upd_value_ff;
      end
      rd_data_ff <= mem_ff[rd_addr];
      rd_zero_ff <= !rd_ok || !vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[upd_addr_ff] <= 1'b1;
         end
         rd_vld_ff <= (state_ff == ST_CONV);
      end
   end

   ssdr_digits u_digits (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff),
      .in_value (cur_value),
      .trio     (trio)
   );

   // shift in three codes per port, shift out one or two per pair beat
   always_ff @(posedge clock) begin
      if (trio.vld) begin
         for (int i = 0; i < SEG_BYTES - 3; i++) begin
            seg_ff[i] <= seg_ff[i+3];
         end
         seg_ff[SEG_BYTES-3] <= trio.hundreds;
         seg_ff[SEG_BYTES-2] <= trio.tens;
         seg_ff[SEG_BYTES-1] <= trio.ones;
      end else if (state_ff == ST_DATA) begin
         if (pair_ff == '0) begin
            for (int i = 0; i < SEG_BYTES - 1; i++) begin
               seg_ff[i] <= seg_ff[i+1];
            end
         end else begin
            for (int i = 0; i < SEG_BYTES - 2; i++) begin
               seg_ff[i] <= seg_ff[i+2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chip_ff      <= '0;
         last_chip_ff <= '0;
         slot_ff      <= '0;
         push_ff      <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (trio.vld) begin
            push_ff <= push_ff + 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start && port_ok) begin
                  upd_addr_ff  <= rd_addr;
                  upd_value_ff <= req_data.value;
                  state_ff     <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               chip_ff <= '0;
               slot_ff <= '0;
               push_ff <= '0;
               if (mem_we && chan_ff == CHAN_TWO_CHIPS) begin
                  last_chip_ff <= 2'd1;
                  state_ff     <= ST_CONV;
               end else if (mem_we && chan_ff == CHAN_FOUR_CHIPS) begin
                  last_chip_ff <= 2'd3;
                  state_ff     <= ST_CONV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CONV: begin
               if (slot_ff == '0) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_ff.chip               <= chip_ff;
                  rsp_ff.first_byte         <= BYTE_SETUP;
                  rsp_ff.second_byte        <= 8'h00;
                  rsp_ff.pair               <= 1'b0;
                  rsp_ff.end_of_transaction <= 1'b1;
                  rsp_ff.last               <= 1'b0;
               end
               slot_ff <= slot_ff + 1'b1;
               if (slot_ff == CNT_W'(PORTS_PER_CHIP - 1)) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (push_ff == CNT_W'(PORTS_PER_CHIP)) begin
                  pair_ff  <= '0;
                  state_ff <= ST_DATA;
               end
            end
            ST_DATA: begin
               rsp_valid_ff              <= 1'b1;
               rsp_ff.chip               <= chip_ff;
               rsp_ff.first_byte         <= (pair_ff == '0) ? BYTE_ADDR : seg_ff[0];
               rsp_ff.second_byte        <= (pair_ff == '0) ? seg_ff[0] : seg_ff[1];
               rsp_ff.pair               <= 1'b1;
               rsp_ff.end_of_transaction <= (pair_ff == CNT_W'(PAIRS - 1));
               rsp_ff.last               <= 1'b0;
               pair_ff <= pair_ff + 1'b1;
               if (pair_ff == CNT_W'(PAIRS - 1)) begin
                  state_ff <= ST_DISPON;
               end
            end
            ST_DISPON: begin
               rsp_valid_ff              <= 1'b1;
               rsp_ff.chip               <= chip_ff;
               rsp_ff.first_byte         <= BYTE_DISP_ON;
               rsp_ff.second_byte        <= 8'h00;
               rsp_ff.pair               <= 1'b0;
               rsp_ff.end_of_transaction <= 1'b1;
               rsp_ff.last               <= (chip_ff == last_chip_ff);
               if (chip_ff == last_chip_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  chip_ff  <= chip_ff + 1'b1;
                  slot_ff  <= '0;
                  push_ff  <= '0;
                  state_ff <= ST_CONV;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= CHAN_RESET;
      end else if (csr_write && paddr[2] == CSR_CHANNEL_COUNT) begin
         chan_ff <= pwdata[CHAN_W-1:0];
      end
   end

   assign prdata    = (paddr[2] == CSR_CHANNEL_COUNT) ? 32'(chan_ff) : 32'd0;
   assign pready    = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SSDR_ASSERT_IMP(a_last_is_disp_on, clock, reset, rsp_valid && rsp_data.last, rsp_data.end_of_transaction && rsp_data.first_byte == BYTE_DISP_ON, "last beat is not display-on")
   `SSDR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy && port_ok, busy, "accepted update did not raise busy")
   `SSDR_ASSERT_IMP(a_push_window, clock, reset, trio.vld, state_ff == ST_CONV || state_ff == ST_WAIT, "digit push outside conversion")
   `SSDR_ASSERT_IMP(a_buffer_full, clock, reset, state_ff == ST_DATA, push_ff == CNT_W'(PORTS_PER_CHIP), "pair beats before buffer filled")

endmodule

/* tb/seven_segment_display_refresher_core_tb.sv */
module seven_segment_display_refresher_core_tb;
   import ssdr_pkg::*;

   localparam int PORTS         = PORTS_DEF;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_UPDATES = 60;
   localparam int PHASES        = 6;

   localparam logic [2:0] ADDR_CHANNEL_COUNT = {CSR_CHANNEL_COUNT, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

   typedef enum logic {ROW_UPDATE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [4:0]   port;
      logic [15:0]  value;
      logic [2:0]   addr;
      logic         silent;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   req_type     req_data;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [7:0]          seg_pattern [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                             8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
   logic [15:0]         shown_values [PORTS];
   logic [CHAN_W-1:0]   channel_setting;
   rsp_type             fresh_beats [$];
   rsp_type             pending_beats [$];
   int                  mismatches = 0;
   int                  beats_checked = 0;
   int                  updates_sent = 0;
   int                  table_changes = 0;
   int                  cycle_count = 0;

   stim_row_type directed_rows [23] = '{
      '{ROW_UPDATE, 5'd1,  16'd0,     ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_UPDATE, 5'd0,  16'd123,   ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_UPDATE, 5'd21, 16'd5,     ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_UPDATE, 5'd31, 16'd65535, ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_UPDATE, 5'd1,  16'd999,   ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd20, 16'd65535, ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd20, 16'd65535, ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_UPDATE, 5'd10, 16'd1000,  ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd5,  16'd12345, ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd11, 16'd4321,  ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_CSR,    5'd0,  16'd10,    ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd3,  16'd456,   ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd15, 16'd789,   ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_CSR,    5'd0,  16'd0,     ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd7,  16'd321,   ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_CSR,    5'd0,  16'd31,    ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd8,  16'd65534, ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_CSR,    5'd0,  16'd10,    ADDR_UNMAPPED,      1'b0},
      '{ROW_UPDATE, 5'd9,  16'd1,     ADDR_CHANNEL_COUNT, 1'b1},
      '{ROW_CSR,    5'd0,  16'd20,    ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd16, 16'd21845, ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd17, 16'd43690, ADDR_CHANNEL_COUNT, 1'b0},
      '{ROW_UPDATE, 5'd1,  16'd0,     ADDR_CHANNEL_COUNT, 1'b0}
   };

   seven_segment_display_refresher_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string msg);
      mismatches++;
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic rsp_type make_beat(input logic [1:0] chip, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic pair,
                                         input logic eot, input logic last_beat);
      rsp_type b;
      b.chip               = chip;
      b.first_byte         = b0;
      b.second_byte        = b1;
      b.pair               = pair;
      b.end_of_transaction = eot;
      b.last               = last_beat;
      return b;
   endfunction

   // Update the shadow table and build the refresh run into fresh_beats.
   function automatic bit predict_update(input req_type r);
      int         chips;
      int         idx;
      int         v;
      logic [7:0] bytes [SEG_BYTES+1];
      fresh_beats.delete();
      if (r.port == 0 || r.port > PORTS) return 1'b0;
      if (shown_values[r.port-1] == r.value) return 1'b0;
      shown_values[r.port-1] = r.value;
      if (channel_setting == CHAN_TWO_CHIPS) chips = 2;
      else if (channel_setting == CHAN_FOUR_CHIPS) chips = 4;
      else chips = 0;
      for (int c = 0; c < chips; c++) begin
         bytes[0] = BYTE_ADDR;
         for (int p = 0; p < PORTS_PER_CHIP; p++) begin
            idx = c * PORTS_PER_CHIP + p;
            v = (idx < PORTS) ? int'(shown_values[idx]) % MOD_DIV : 0;
            bytes[1+3*p] = seg_pattern[v / HUNDRED];
            bytes[2+3*p] = seg_pattern[(v % HUNDRED) / TEN];
            bytes[3+3*p] = seg_pattern[v % TEN];
         end
         fresh_beats.push_back(make_beat(2'(c), BYTE_SETUP, 8'h00, 1'b0, 1'b1, 1'b0));
         for (int i = 0; i + 1 < SEG_BYTES + 1; i += 2)
            fresh_beats.push_back(make_beat(2'(c), bytes[i], bytes[i+1], 1'b1,
                                            i + 2 >= SEG_BYTES + 1, 1'b0));
         fresh_beats.push_back(make_beat(2'(c), BYTE_DISP_ON, 8'h00, 1'b0, 1'b1,
                                         c == chips - 1));
      end
      return 1'b1;
   endfunction

   function automatic req_type random_update();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) r.port = 5'd0;
      else if (pick < 8) r.port = 5'($urandom_range(PORTS + 1, 31));
      else r.port = 5'($urandom_range(1, PORTS));
      pick = $urandom_range(0, 99);
      if (pick < 15 && r.port >= 1 && r.port <= PORTS) r.value = shown_values[r.port-1];
      else if (pick < 35) r.value = 16'($urandom_range(0, 999));
      else if (pick < 45) begin
         case ($urandom_range(0, 3))
            0: r.value = 16'd0;
            1: r.value = 16'd999;
            2: r.value = 16'd1000;
            default: r.value = 16'hFFFF;
         endcase
      end else r.value = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic send_update(input req_type r, input bit silent, output bit changed);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      changed = predict_update(r);
      updates_sent++;
      if (changed) table_changes++;
      if (!silent)
         foreach (fresh_beats[k]) pending_beats.push_back(fresh_beats[k]);
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   task automatic csr_access(input bit write, input logic [2:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write only once the block has gone quiet, then read the count back.
   task automatic write_channels(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] readback;
      drain();
      while (busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, addr, data, readback);
      if (addr == ADDR_CHANNEL_COUNT) channel_setting = data[CHAN_W-1:0];
      csr_access(1'b0, ADDR_CHANNEL_COUNT, 32'd0, readback);
      if (readback !== 32'(channel_setting))
         report($sformatf("channel count read %0d, want %0d", readback, channel_setting));
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            report($sformatf("beat %h with none outstanding", rsp_data));
         end else begin
            want = pending_beats.pop_front();
            beats_checked++;
            check_field("chip", 8'(rsp_data.chip), 8'(want.chip));
            check_field("first_byte", rsp_data.first_byte, want.first_byte);
            check_field("second_byte", rsp_data.second_byte, want.second_byte);
            check_field("pair", 8'(rsp_data.pair), 8'(want.pair));
            check_field("end_of_transaction", 8'(rsp_data.end_of_transaction),
                        8'(want.end_of_transaction));
            check_field("last", 8'(rsp_data.last), 8'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired with %0d beats outstanding", pending_beats.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_type           r;
      bit                changed;
      int                phase_sent;
      int                burst_left;
      logic [CHAN_W-1:0] phase_plan [PHASES];
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      foreach (shown_values[i]) shown_values[i] = '0;
      channel_setting = CHAN_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_channels(directed_rows[i].addr, 32'(directed_rows[i].value));
         end else begin
            r.port  = directed_rows[i].port;
            r.value = directed_rows[i].value;
            send_update(r, directed_rows[i].silent, changed);
            idle($urandom_range(0, 3));
         end
      end

      phase_plan = '{CHAN_FOUR_CHIPS, CHAN_TWO_CHIPS, 5'($urandom_range(0, 31)),
                     CHAN_FOUR_CHIPS, CHAN_TWO_CHIPS, CHAN_FOUR_CHIPS};
      for (int ph = 0; ph < PHASES; ph++) begin
         write_channels(ADDR_CHANNEL_COUNT, 32'(phase_plan[ph]));
         phase_sent = 0;
         burst_left = $urandom_range(1, 10);
         while (phase_sent < PHASE_UPDATES) begin
            r = random_update();
            send_update(r, 1'b0, changed);
            phase_sent++;
            if ($urandom_range(0, 39) == 0) begin
               drain();
            end else if (burst_left == 0) begin
               burst_left = $urandom_range(1, 10);
               idle($urandom_range(0, 90));
            end else begin
               burst_left--;
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d port updates, %0d of them changed a value; checked %0d refresh beats.",
               updates_sent, table_changes, beats_checked);
      $display("Channel counts 0, 10, 20, 31 and a random one; an unmapped register write too.");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
